// File: sv/gpr_pkg.sv
// ----------------------------------------------------------------------------
// gpr_pkg
// Shared types and constants for the grid path reachability block: cell and
// status codes, register indexes, neighbour order and sequencer states.
// ----------------------------------------------------------------------------
package gpr_pkg;

	localparam int DEF_MAX_SIDE = 64;

	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CODE_W    = 2;
	localparam int STATUS_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

	localparam logic [CFG_W-1:0] SIDE_RST = 7'd64;

	typedef enum logic [CODE_W-1:0] {
		CELL_WALL,
		CELL_SOURCE,
		CELL_DEST,
		CELL_BLANK
	} cell_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_PATH,
		ST_NO_PATH,
		ST_NO_SOURCE,
		ST_BAD_LENGTH
	} status_t;

	typedef enum logic [1:0] {
		NB_DOWN,
		NB_RIGHT,
		NB_UP,
		NB_LEFT
	} nb_t;

	typedef enum logic [2:0] {
		S_LOAD,
		S_DIV,
		S_EV,
		S_POP,
		S_POPW,
		S_NB,
		S_DONE
	} state_t;

endpackage

// File: sv/grid_path_reachability.sv
// ----------------------------------------------------------------------------
// grid_path_reachability
// Loads a grid of cell codes, then runs a depth-first flood fill from the
// first source with an explicit stack and reports whether a destination is
// reachable.
// ----------------------------------------------------------------------------
// Usage:
//  Cell channel (cell_valid/cell_stall, cell_code, last_cell): one cell per
//  beat in row-major order; a beat with last_cell set closes the grid. Cells
//  are taken one per cycle while loading.
//  Status channel (status_valid/status_stall, search_status): one beat per
//  grid, held in an output register until taken.
//  Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): grid_rows and
//  grid_cols, always ready; write only between grids.
//  After the last cell the cell channel stalls while the search runs. On a
//  length mismatch or missing source, the search is skipped: the sequencer
//  goes straight to its final state, from which status_valid is registered.
//  Otherwise the source row is found by repeated subtraction, then each
//  cell pushed is popped through S_POP and S_POPW, each neighbour is checked
//  in S_NB and each neighbour in bounds is read from the cell memory in S_EV;
//  the search speed is set by the single memory port shared by all neighbour
//  checks.
//  The output register frees the sequencer unless a second status is ready
//  while the first is still stalled; then the sequencer holds in its final
//  state and the cell channel stays stalled.
//  Reset empties the load, the stack and the output and restores 64 by 64.
// ----------------------------------------------------------------------------
module grid_path_reachability
	import gpr_pkg::*;
#(
	parameter int MAX_SIDE = DEF_MAX_SIDE
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cell_valid,
	output logic                 cell_stall,
	input  logic [CODE_W-1:0]    cell_code,
	input  logic                 last_cell,
	output logic                 status_valid,
	input  logic                 status_stall,
	output logic [STATUS_W-1:0]  search_status,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int CELLS = MAX_SIDE * MAX_SIDE;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int RW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int SW    = $clog2(MAX_SIDE + 1);
	localparam int SW1   = SW + 1;
	localparam int PW    = 2 * SW;
	localparam int TW    = $clog2(CELLS + 1);
	localparam int CW    = $clog2(CELLS + 2);
	localparam int EW    = AW + 2 * RW;
	localparam int MW    = CODE_W + 1;

	state_t               state_q, state_d;
	logic [CFG_W-1:0]     grid_rows_q, grid_cols_q;
	logic [CW-1:0]        load_cnt_q, cnt_d;
	logic                 seen_q, seen_d;
	logic [AW-1:0]        src_pos_q, src_d;
	logic [SW-1:0]        rows_w, cols_w, rows_q, cols_q;
	logic [TW-1:0]        total_w;
	logic                 cell_acc, load_wr, last_bad, is_src;
	logic [AW-1:0]        srch_src_q, rem_q;
	logic [RW-1:0]        div_r_q;
	logic                 div_more;
	logic [AW-1:0]        cand_idx_q, cur_idx_q, nb_idx;
	logic [RW-1:0]        cand_r_q, cand_c_q, cur_r_q, cur_c_q, nb_r, nb_c;
	nb_t                  nb_q;
	logic                 nb_ok, from_src_q;
	logic [CW-1:0]        sp_q;
	logic [AW-1:0]        stk_raddr;
	logic                 stk_we;
	logic [EW-1:0]        stk_rd_q;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr, mem_raddr;
	logic [MW-1:0]        mem_wdata, mem_rd_q;
	cell_t                try_code;
	logic                 try_pass, try_hit;
	status_t              res_q;
	logic                 status_valid_q, done_fire;
	logic [STATUS_W-1:0]  status_q;

	logic [MW-1:0] cell_mem  [CELLS];
	logic [EW-1:0] stack_mem [CELLS];

	assign cfg_ready     = 1'b1;
	assign cell_stall    = (state_q != S_LOAD);
	assign status_valid  = status_valid_q;
	assign search_status = status_q;

	always_comb begin
		if (grid_rows_q == '0) begin
			rows_w = SW'(1);
		end else if (int'(grid_rows_q) > MAX_SIDE) begin
			rows_w = SW'(MAX_SIDE);
		end else begin
			rows_w = SW'(grid_rows_q);
		end
		if (grid_cols_q == '0) begin
			cols_w = SW'(1);
		end else if (int'(grid_cols_q) > MAX_SIDE) begin
			cols_w = SW'(MAX_SIDE);
		end else begin
			cols_w = SW'(grid_cols_q);
		end
	end

	assign total_w  = TW'(PW'(rows_w) * PW'(cols_w));
	assign cell_acc = cell_valid && !cell_stall;
	assign load_wr  = cell_acc && (load_cnt_q < CW'(total_w));
	assign is_src   = load_wr && (cell_t'(cell_code) == CELL_SOURCE);
	assign seen_d   = seen_q || is_src;
	assign src_d    = (is_src && !seen_q) ? load_cnt_q[AW-1:0] : src_pos_q;

	always_comb begin
		cnt_d = load_cnt_q;
		if (load_wr || (cell_acc && load_cnt_q == CW'(total_w))) begin
			cnt_d = load_cnt_q + CW'(1);
		end
	end

	assign last_bad = (cnt_d != CW'(total_w));
	assign div_more = (rem_q >= AW'(cols_q));

	assign try_code = cell_t'(mem_rd_q[CODE_W-1:0]);
	assign try_pass = (try_code != CELL_WALL) && !mem_rd_q[CODE_W];
	assign try_hit  = try_pass && (try_code == CELL_DEST);

	always_comb begin
		nb_ok  = 1'b0;
		nb_idx = cur_idx_q;
		nb_r   = cur_r_q;
		nb_c   = cur_c_q;
		unique case (nb_q)
			NB_DOWN: begin
				nb_ok  = (SW1'(cur_r_q) + SW1'(1)) < SW1'(rows_q);
				nb_idx = cur_idx_q + AW'(cols_q);
				nb_r   = cur_r_q + RW'(1);
			end
			NB_RIGHT: begin
				nb_ok  = (SW1'(cur_c_q) + SW1'(1)) < SW1'(cols_q);
				nb_idx = cur_idx_q + AW'(1);
				nb_c   = cur_c_q + RW'(1);
			end
			NB_UP: begin
				nb_ok  = (cur_r_q != '0);
				nb_idx = cur_idx_q - AW'(cols_q);
				nb_r   = cur_r_q - RW'(1);
			end
			NB_LEFT: begin
				nb_ok  = (cur_c_q != '0);
				nb_idx = cur_idx_q - AW'(1);
				nb_c   = cur_c_q - RW'(1);
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
	end

	assign done_fire = (state_q == S_DONE) && (!status_valid_q || !status_stall);
	assign stk_raddr = AW'(sp_q - CW'(1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_LOAD: begin
				if (cell_acc && last_cell) begin
					state_d = (last_bad || !seen_d) ? S_DONE : S_DIV;
				end
			end
			S_DIV: begin
				if (!div_more) begin
					state_d = S_EV;
				end
			end
			S_EV: begin
				if (try_hit) begin
					state_d = S_DONE;
				end else if (from_src_q || nb_q == NB_LEFT) begin
					state_d = S_POP;
				end else begin
					state_d = S_NB;
				end
			end
			S_POP: begin
				state_d = (sp_q == '0) ? S_DONE : S_POPW;
			end
			S_POPW: begin
				state_d = S_NB;
			end
			S_NB: begin
				if (nb_ok) begin
					state_d = S_EV;
				end else if (nb_q == NB_LEFT) begin
					state_d = S_POP;
				end
			end
			S_DONE: begin
				if (done_fire) begin
					state_d = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	// memory controls
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = load_cnt_q[AW-1:0];
		mem_wdata = {1'b0, cell_code};
		stk_we    = 1'b0;
		mem_raddr = (state_q == S_DIV) ? srch_src_q : nb_idx;
		if (state_q == S_LOAD && load_wr) begin
			mem_we = 1'b1;
		end else if (state_q == S_EV && try_pass && !try_hit) begin
			mem_we    = 1'b1;
			mem_waddr = cand_idx_q;
			mem_wdata = {1'b1, mem_rd_q[CODE_W-1:0]};
			stk_we    = (sp_q < CW'(CELLS));
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cell_mem[mem_waddr] <= mem_wdata;
		end
		mem_rd_q <= cell_mem[mem_raddr];
		if (stk_we) begin
			stack_mem[sp_q[AW-1:0]] <= {cand_idx_q, cand_r_q, cand_c_q};
		end
		stk_rd_q <= stack_mem[stk_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_LOAD;
			grid_rows_q    <= SIDE_RST;
			grid_cols_q    <= SIDE_RST;
			load_cnt_q     <= '0;
			seen_q         <= 1'b0;
			src_pos_q      <= '0;
			sp_q           <= '0;
			nb_q           <= NB_DOWN;
			from_src_q     <= 1'b0;
			status_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_GRID_ROWS: grid_rows_q <= cfg_data;
					REG_GRID_COLS: grid_cols_q <= cfg_data;
					default: ;
				endcase
			end
			if (cell_acc) begin
				if (last_cell) begin
					load_cnt_q <= '0;
					seen_q     <= 1'b0;
					src_pos_q  <= '0;
					sp_q       <= '0;
					from_src_q <= 1'b1;
				end else begin
					load_cnt_q <= cnt_d;
					seen_q     <= seen_d;
					src_pos_q  <= src_d;
				end
			end
			unique case (state_q)
				S_EV: begin
					if (stk_we) begin
						sp_q <= sp_q + CW'(1);
					end
					if (!from_src_q && nb_q != NB_LEFT) begin
						nb_q <= nb_t'(nb_q + 2'd1);
					end
				end
				S_POP: begin
					if (sp_q != '0) begin
						sp_q <= sp_q - CW'(1);
					end
				end
				S_POPW: begin
					nb_q       <= NB_DOWN;
					from_src_q <= 1'b0;
				end
				S_NB: begin
					if (!nb_ok && nb_q != NB_LEFT) begin
						nb_q <= nb_t'(nb_q + 2'd1);
					end
				end
				default: ;
			endcase
			if (done_fire) begin
				status_valid_q <= 1'b1;
			end else if (!status_stall) begin
				status_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			status_q <= res_q;
		end
		unique case (state_q)
			S_LOAD: begin
				if (cell_acc && last_cell) begin
					rows_q     <= rows_w;
					cols_q     <= cols_w;
					srch_src_q <= src_d;
					rem_q      <= src_d;
					div_r_q    <= '0;
					res_q      <= last_bad ? ST_BAD_LENGTH : ST_NO_SOURCE;
				end
			end
			S_DIV: begin
				if (div_more) begin
					rem_q   <= rem_q - AW'(cols_q);
					div_r_q <= div_r_q + RW'(1);
				end else begin
					cand_idx_q <= srch_src_q;
					cand_r_q   <= div_r_q;
					cand_c_q   <= RW'(rem_q);
				end
			end
			S_EV: begin
				if (try_hit) begin
					res_q <= ST_PATH;
				end
			end
			S_POP: begin
				if (sp_q == '0) begin
					res_q <= ST_NO_PATH;
				end
			end
			S_POPW: begin
				{cur_idx_q, cur_r_q, cur_c_q} <= stk_rd_q;
			end
			S_NB: begin
				if (nb_ok) begin
					cand_idx_q <= nb_idx;
					cand_r_q   <= nb_r;
					cand_c_q   <= nb_c;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: test/grid_path_checker.sv
// ----------------------------------------------------------------------------
// grid_path_checker
// Watches the cell, status and register channels of grid_path_reachability.
// Keeps its own copy of the grid, the load count and the register values,
// runs a depth-first flood fill on every closed grid of the right length with
// a source and compares each status beat with the oldest predicted status.
// ----------------------------------------------------------------------------
module grid_path_checker
	import gpr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cell_valid,
	input  logic                 cell_stall,
	input  logic [CODE_W-1:0]    cell_code,
	input  logic                 last_cell,
	input  logic                 status_valid,
	input  logic                 status_stall,
	input  logic [STATUS_W-1:0]  search_status,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   pending,
	output int                   checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SIDE = DEF_MAX_SIDE;
	localparam int AREA = SIDE * SIDE;

	cell_t            grid_mem [AREA];
	bit               seen [AREA];
	int               fill_stack [AREA];
	int               fill_top;
	logic [CFG_W-1:0] rows_reg = SIDE_RST;
	logic [CFG_W-1:0] cols_reg = SIDE_RST;
	int               load_len = 0;
	int               src_pos = 0;
	bit               src_found = 1'b0;
	status_t          status_q [$];
	int               n_fail = 0;
	int               n_checked = 0;

	function automatic int eff_side(logic [CFG_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > SIDE)
			return SIDE;
		return int'(v);
	endfunction

	// mark and push a passable cell; report a destination
	function automatic bit visit(int idx);
		if (idx < 0 || idx >= AREA)
			return 1'b0;
		if (grid_mem[idx] == CELL_WALL || seen[idx])
			return 1'b0;
		if (grid_mem[idx] == CELL_DEST)
			return 1'b1;
		seen[idx] = 1'b1;
		if (fill_top < AREA) begin
			fill_stack[fill_top] = idx;
			fill_top++;
		end
		return 1'b0;
	endfunction

	function automatic bit reach_dest(int rows, int cols);
		int idx;
		int nb [4];
		bit ok [4];
		foreach (seen[i])
			seen[i] = 1'b0;
		fill_top = 0;
		if (visit(src_pos))
			return 1'b1;
		while (fill_top > 0) begin
			fill_top--;
			idx = fill_stack[fill_top];
			nb[NB_DOWN]  = idx + cols;
			ok[NB_DOWN]  = (idx / cols) + 1 < rows;
			nb[NB_RIGHT] = idx + 1;
			ok[NB_RIGHT] = (idx % cols) + 1 < cols;
			nb[NB_UP]    = idx - cols;
			ok[NB_UP]    = (idx / cols) > 0;
			nb[NB_LEFT]  = idx - 1;
			ok[NB_LEFT]  = (idx % cols) > 0;
			for (int k = 0; k < 4; k++)
				if (ok[k] && visit(nb[k]))
					return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic take_cell(cell_t code, logic last);
		int rows;
		int cols;
		int total;
		status_t verdict;
		rows  = eff_side(rows_reg);
		cols  = eff_side(cols_reg);
		total = rows * cols;
		if (load_len < total) begin
			grid_mem[load_len] = code;
			if (code == CELL_SOURCE && !src_found) begin
				src_found = 1'b1;
				src_pos   = load_len;
			end
			load_len++;
		end else if (load_len == total) begin
			load_len++;
		end
		if (last) begin
			if (load_len != total)
				verdict = ST_BAD_LENGTH;
			else if (!src_found)
				verdict = ST_NO_SOURCE;
			else if (reach_dest(rows, cols))
				verdict = ST_PATH;
			else
				verdict = ST_NO_PATH;
			status_q.push_back(verdict);
			load_len  = 0;
			src_found = 1'b0;
			src_pos   = 0;
		end
	endtask

	task automatic take_status(logic [STATUS_W-1:0] got);
		status_t want;
		if (status_q.size() == 0) begin
			if (n_fail < 10)
				$display("%0t: status beat with none pending, search_status=%0d", $time, got);
			n_fail++;
		end else begin
			want = status_q.pop_front();
			n_checked++;
			if (got !== want) begin
				if (n_fail < 10)
					$display("%0t: grid %0d search_status expected %0d (%s) got %0d",
						$time, n_checked, want, want.name(), got);
				n_fail++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_reg  = SIDE_RST;
			cols_reg  = SIDE_RST;
			load_len  = 0;
			src_pos   = 0;
			src_found = 1'b0;
			n_fail    = 0;
			n_checked = 0;
			status_q.delete();
			fail_count <= 0;
			pending    <= 0;
			checked    <= 0;
		end else begin
			if (status_valid && !status_stall)
				take_status(search_status);
			if (cell_valid && !cell_stall)
				take_cell(cell_t'(cell_code), last_cell);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_GRID_ROWS)
					rows_reg = cfg_data;
				else
					cols_reg = cfg_data;
			end
			fail_count <= n_fail;
			pending    <= status_q.size();
			checked    <= n_checked;
		end
	end

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives grid_path_reachability with directed grids covering every cell code,
// short and overlong loads, missing and repeated sources, then random grids
// over many row and column settings including the clamped extremes, with
// random gaps on both channels and one long status hold-off.
// ----------------------------------------------------------------------------
module tb_top
	import gpr_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD = 5;
	localparam int CELL_TARGET = 1850;
	localparam int SETTLE      = 16;
	localparam int HOLD_CYCLES = 400;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cell_valid = 1'b0;
	logic                 cell_stall;
	logic [CODE_W-1:0]    cell_code = '0;
	logic                 last_cell = 1'b0;
	logic                 status_valid;
	logic                 status_stall = 1'b0;
	logic [STATUS_W-1:0]  search_status;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	int    fail_count;
	int    pending;
	int    checked;
	int    cells_sent = 0;
	int    cfg_writes = 0;
	int    rows_cur = DEF_MAX_SIDE;
	int    cols_cur = DEF_MAX_SIDE;
	bit    calm = 1'b0;
	bit    hold_req = 1'b0;
	cell_t grid [$];

	grid_path_reachability u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cell_valid    (cell_valid),
		.cell_stall    (cell_stall),
		.cell_code     (cell_code),
		.last_cell     (last_cell),
		.status_valid  (status_valid),
		.status_stall  (status_stall),
		.search_status (search_status),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	grid_path_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cell_valid    (cell_valid),
		.cell_stall    (cell_stall),
		.cell_code     (cell_code),
		.last_cell     (last_cell),
		.status_valid  (status_valid),
		.status_stall  (status_stall),
		.search_status (search_status),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked       (checked)
	);

	always #HALF_PERIOD clk = ~clk;

	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end

	// status side: random hold before each beat, one long hold on request
	initial begin
		int gap;
		bit held;
		held = 1'b0;
		forever begin
			if (hold_req && !held) begin
				gap  = HOLD_CYCLES;
				held = 1'b1;
			end else begin
				gap = calm ? 0 : $urandom_range(0, 15);
			end
			if (gap > 0) begin
				status_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			status_stall <= 1'b0;
			do @(posedge clk); while (!(status_valid && !status_stall));
		end
	end

	task automatic send_cell(cell_t code, logic last);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			cell_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cell_valid <= 1'b1;
		cell_code  <= code;
		last_cell  <= last;
		do @(posedge clk); while (cell_stall);
		cells_sent++;
	endtask

	task automatic send_grid(int len);
		for (int i = 0; i < len; i++)
			send_cell(grid[i], i == len - 1);
	endtask

	// drop valid, wait for every status, then let the sequencer settle
	task automatic drain();
		cell_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_grid(logic [CFG_W-1:0] r, logic [CFG_W-1:0] c);
		cfg_valid <= 1'b1;
		cfg_index <= REG_GRID_ROWS;
		cfg_data  <= r;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_GRID_COLS;
		cfg_data  <= c;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes += 2;
		rows_cur = (r == '0) ? 1 : ((r > DEF_MAX_SIDE) ? DEF_MAX_SIDE : int'(r));
		cols_cur = (c == '0) ? 1 : ((c > DEF_MAX_SIDE) ? DEF_MAX_SIDE : int'(c));
	endtask

	task automatic random_grid(int rows, int cols);
		int area;
		int len;
		int wall_pct;
		bit noise;
		area     = rows * cols;
		wall_pct = $urandom_range(0, 60);
		noise    = ($urandom_range(0, 9) == 0);
		grid.delete();
		for (int i = 0; i < area; i++) begin
			if (noise)
				grid.push_back(cell_t'($urandom_range(0, 3)));
			else
				grid.push_back(($urandom_range(0, 99) < wall_pct) ? CELL_WALL : CELL_BLANK);
		end
		if ($urandom_range(0, 9) != 0)
			grid[$urandom_range(0, area - 1)] = CELL_SOURCE;
		if ($urandom_range(0, 4) == 0)
			grid[$urandom_range(0, area - 1)] = CELL_SOURCE;
		repeat ($urandom_range(0, 3))
			grid[$urandom_range(0, area - 1)] = CELL_DEST;
		case ($urandom_range(0, 9))
			0: len = (area > 1) ? $urandom_range(1, area - 1) : area + 1;
			1: len = area + $urandom_range(1, 3);
			default: len = area;
		endcase
		while (grid.size() < len)
			grid.push_back(cell_t'($urandom_range(0, 3)));
		send_grid(len);
	endtask

	initial begin
		bit burst_done;
		bit snake_done;
		burst_done = 1'b0;
		snake_done = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single cell against the reset size of 64 by 64
		send_cell(CELL_WALL, 1'b1);
		drain();

		set_grid(7'd0, 7'd1);
		send_cell(CELL_WALL, 1'b1);
		send_cell(CELL_SOURCE, 1'b1);
		send_cell(CELL_DEST, 1'b1);
		send_cell(CELL_BLANK, 1'b1);
		drain();

		// path through a second source; blocked source; overlong load
		set_grid(7'd2, 7'd3);
		grid = '{CELL_SOURCE, CELL_BLANK, CELL_SOURCE, CELL_WALL, CELL_WALL, CELL_DEST};
		send_grid(6);
		grid = '{CELL_SOURCE, CELL_WALL, CELL_DEST, CELL_BLANK, CELL_WALL, CELL_BLANK};
		send_grid(6);
		grid = '{CELL_SOURCE, CELL_BLANK, CELL_BLANK, CELL_BLANK,
			CELL_BLANK, CELL_DEST, CELL_WALL, CELL_DEST};
		send_grid(8);

		while (cells_sent < CELL_TARGET) begin
			drain();
			if (!burst_done && cells_sent > 400) begin
				set_grid(7'd2, 7'd2);
				calm     = 1'b1;
				hold_req = 1'b1;
				repeat (12) random_grid(rows_cur, cols_cur);
				calm       = 1'b0;
				burst_done = 1'b1;
			end else if (!snake_done && cells_sent > 900) begin
				// winding corridor over the full row count
				set_grid(7'd64, 7'd16);
				grid.delete();
				for (int r = 0; r < rows_cur; r++)
					for (int c = 0; c < cols_cur; c++)
						grid.push_back((r % 2 == 1 && c != ((r % 4 == 1) ? cols_cur - 1 : 0))
							? CELL_WALL : CELL_BLANK);
				grid[0] = CELL_SOURCE;
				grid[rows_cur * cols_cur - 1] = CELL_DEST;
				send_grid(rows_cur * cols_cur);
				snake_done = 1'b1;
			end else begin
				case ($urandom_range(0, 9))
					0: set_grid(7'd0, 7'($urandom_range(0, 8)));
					1: set_grid(7'($urandom_range(64, 127)), 7'($urandom_range(0, 1)));
					2: set_grid(7'd1, 7'($urandom_range(64, 127)));
					3: set_grid(7'($urandom_range(1, 16)), 7'($urandom_range(1, 16)));
					default: set_grid(7'($urandom_range(1, 6)), 7'($urandom_range(1, 6)));
				endcase
				calm = ($urandom_range(0, 3) == 0);
				repeat ($urandom_range(1, 6)) random_grid(rows_cur, cols_cur);
				calm = 1'b0;
			end
		end
		drain();

		$display("Sent %0d cells over %0d register writes.", cells_sent, cfg_writes);
		$display("Checked %0d grid statuses, %0d mismatches.", checked, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
